// ----- design/bpcr_pkg.sv -----
// bpcr_pkg: shared types and constants for the buffer pool clock replacement block
// transfer payloads, controller command/status bundles and default sizes
// no dependencies
package bpcr_pkg;

  // default sizing
  localparam int FRAMES_DEF    = 1024;
  localparam int PAGE_BITS_DEF = 16;

  // access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // input transfer payload
  typedef struct packed {
    logic        command;
    logic [15:0] page;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic        hit;
    logic [9:0]  frame;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic        load_needed;
    logic        store_needed;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic scan;
    logic hit_commit;
    logic sweep_rd;
    logic sweep_chk;
    logic victim_commit;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic scan_hit;
    logic scan_miss;
    logic ref_set;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- design/bpcr_ram.sv -----
// bpcr_ram: generic single write port, single read port memory
// registered read data, contents undefined until written; no dependencies
module bpcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ----- design/bpcr_datapath.sv -----
// bpcr_datapath: tag and reference bit memories, clock hand, fill count,
// tag scan pipeline and result register; uses bpcr_pkg and bpcr_ram
module bpcr_datapath
  import bpcr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int FW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);

  // item registers
  logic [PAGE_BITS-1:0] page_r;
  logic                 cmd_r;
  logic [PAGE_BITS+15:0] page_ext;

  // scan pipeline
  logic [CW-1:0] scan_addr_r, scan_addr_nxt;
  logic [FW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          pend_r, pend_nxt;
  logic          scan_more;
  logic          scan_issue;

  // replacement state
  logic [FW-1:0] hand_r, hand_nxt;
  logic [FW-1:0] hand_inc;
  logic [CW-1:0] fill_r, fill_nxt;

  // result registers
  logic [FW-1:0] where_r, where_nxt;
  logic          hit_r, hit_nxt;
  logic          ev_valid_r, ev_valid_nxt;
  logic [15:0]   ev_page_r, ev_page_nxt;
  logic          victim_valid;
  logic [PAGE_BITS+15:0] tag_ext;
  logic [FW+9:0] frame_ext;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // memory ports
  logic                 tag_we, tag_re;
  logic [FW-1:0]        tag_raddr;
  logic [PAGE_BITS-1:0] tag_rdata;
  logic                 ref_we;
  logic [FW-1:0]        ref_waddr;
  logic                 ref_wdata;
  logic                 ref_rdata;

  bpcr_ram #(.WIDTH(PAGE_BITS), .DEPTH(FRAMES)) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (where_r),
    .wr_data (page_r),
    .rd_en   (tag_re),
    .rd_addr (tag_raddr),
    .rd_data (tag_rdata)
  );

  bpcr_ram #(.WIDTH(1), .DEPTH(FRAMES)) u_ref_ram (
    .clk     (clk),
    .wr_en   (ref_we),
    .wr_addr (ref_waddr),
    .wr_data (ref_wdata),
    .rd_en   (cmd.sweep_rd),
    .rd_addr (hand_r),
    .rd_data (ref_rdata)
  );

  // page reduced to the tag width
  assign page_ext = (PAGE_BITS + 16)'(in_data.page);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page_r <= page_ext[PAGE_BITS-1:0];
      cmd_r  <= in_data.command;
    end
  end

  // tag scan over the filled frames, one read per cycle
  assign scan_more  = scan_addr_r < fill_r;
  assign sts.scan_hit  = pend_r && (tag_rdata == page_r);
  assign sts.scan_miss = !pend_r && !scan_more;
  assign scan_issue = cmd.scan && scan_more && !sts.scan_hit;

  always_comb begin
    scan_addr_nxt = scan_addr_r;
    cmp_idx_nxt   = cmp_idx_r;
    pend_nxt      = 1'b0;
    if (cmd.accept) begin
      scan_addr_nxt = '0;
    end else if (scan_issue) begin
      scan_addr_nxt = scan_addr_r + 1'b1;
      cmp_idx_nxt   = scan_addr_r[FW-1:0];
      pend_nxt      = 1'b1;
    end
  end

  // tag memory access
  assign tag_raddr = cmd.scan ? scan_addr_r[FW-1:0] : hand_r;
  assign tag_re    = scan_issue || (cmd.sweep_chk && !ref_rdata);
  assign tag_we    = cmd.victim_commit;

  // clock hand, also the address counter of the clearing pass
  assign hand_inc       = (hand_r == FW'(FRAMES - 1)) ? '0 : hand_r + 1'b1;
  assign sts.clear_last = hand_r == FW'(FRAMES - 1);
  assign sts.ref_set    = ref_rdata;

  always_comb begin
    hand_nxt = hand_r;
    if (cmd.clear_step || cmd.sweep_chk) begin
      hand_nxt = hand_inc;
    end
  end

  // reference bit writes: set on clear and hit, flipped during the sweep
  assign ref_we    = cmd.clear_step || cmd.hit_commit || cmd.sweep_chk;
  assign ref_waddr = cmd.hit_commit ? cmp_idx_r : hand_r;
  assign ref_wdata = (cmd.clear_step || cmd.hit_commit) ? 1'b1 : !ref_rdata;

  // frames fill in hand order, so a frame is valid below the fill count
  assign victim_valid = CW'(where_r) < fill_r;
  assign tag_ext      = (PAGE_BITS + 16)'(tag_rdata);

  always_comb begin
    where_nxt    = where_r;
    hit_nxt      = hit_r;
    ev_valid_nxt = ev_valid_r;
    ev_page_nxt  = ev_page_r;
    fill_nxt     = fill_r;
    if (cmd.hit_commit) begin
      where_nxt    = cmp_idx_r;
      hit_nxt      = 1'b1;
      ev_valid_nxt = 1'b0;
      ev_page_nxt  = '0;
    end
    if (cmd.sweep_chk && !ref_rdata) begin
      where_nxt = hand_r;
    end
    if (cmd.victim_commit) begin
      hit_nxt      = 1'b0;
      ev_valid_nxt = victim_valid;
      ev_page_nxt  = victim_valid ? tag_ext[15:0] : '0;
      if (!victim_valid) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  // result register, free once the held transfer is taken
  assign sts.out_free = !out_valid_r || !out_stall;
  assign frame_ext    = (FW + 10)'(where_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.hit           <= hit_r;
      out_data_r.frame         <= frame_ext[9:0];
      out_data_r.evicted_valid <= ev_valid_r;
      out_data_r.evicted_page  <= ev_page_r;
      out_data_r.load_needed   <= !hit_r;
      out_data_r.store_needed  <= cmd_r == CMD_WRITE;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_r      <= '0;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hand_r      <= hand_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    where_r     <= where_nxt;
    hit_r       <= hit_nxt;
    ev_valid_r  <= ev_valid_nxt;
    ev_page_r   <= ev_page_nxt;
  end

endmodule

// ----- design/bpcr_ctrl.sv -----
// bpcr_ctrl: sequencing state machine for clearing, lookup, sweep and result
// uses bpcr_pkg command and status bundles
module bpcr_ctrl
  import bpcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_SCAN      = 7'b0000100,
    ST_SWEEP_RD  = 7'b0001000,
    ST_SWEEP_CHK = 7'b0010000,
    ST_VICTIM    = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = state_r != ST_IDLE;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit) begin
          cmd.hit_commit = 1'b1;
          state_nxt      = ST_DONE;
        end else if (sts.scan_miss) begin
          state_nxt = ST_SWEEP_RD;
        end
      end
      ST_SWEEP_RD: begin
        cmd.sweep_rd = 1'b1;
        state_nxt    = ST_SWEEP_CHK;
      end
      ST_SWEEP_CHK: begin
        cmd.sweep_chk = 1'b1;
        state_nxt     = sts.ref_set ? ST_SWEEP_RD : ST_VICTIM;
      end
      ST_VICTIM: begin
        cmd.victim_commit = 1'b1;
        state_nxt         = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/buffer_pool_clock_replacement.sv -----
// Buffer pool frame manager with CLOCK replacement. Each accepted access returns the frame
// holding its page; a miss sweeps the clock hand for a victim and reports any evicted page.
// After reset the block runs a clearing pass over all FRAMES frames that sets every reference
// bit, and accepts no access until it ends. An accepted access then scans the tags of the
// frames filled so far (at most FRAMES), stopping at the matching frame on a hit; the tag
// memory is searched one entry per cycle through its single read port. A miss then sweeps
// the hand, each step reading one reference bit and then checking and writing it (1 to
// FRAMES+1 steps), and commits the victim. Either way the result is then loaded into the
// output register. The next access is taken while that result waits to be
// transferred.
module buffer_pool_clock_replacement
  import bpcr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencing
  bpcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memories, hand and result register
  bpcr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- verif/tb.sv -----
// tb: self-checking bench for the buffer pool clock replacement block
// directed table then random page accesses, checked against table results where given, else a clock-sweep predictor
// depends on bpcr_pkg and buffer_pool_clock_replacement
module tb
  import bpcr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFRAMES     = FRAMES_DEF;
  localparam int RAND_ITEMS  = 1534;
  localparam int STALL_LIMIT = 20000;
  localparam int HIST_DEPTH  = 48;

  // one row of the directed table
  typedef struct {
    in_item_t  acc;
    bit        known;
    out_item_t res;
  } access_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // predictor state
  logic [15:0] page_of [NFRAMES];
  bit          held [NFRAMES];
  bit          refb [NFRAMES];
  int          hand;

  out_item_t   pending_frames [$];
  logic [15:0] recent_pages [$];
  logic [15:0] evicted_pages [$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  hit_count = 0;
  int  miss_count = 0;
  int  evict_count = 0;
  int  full_turns = 0;
  int  longest_sweep = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;

  // frames fill in order after reset; the first miss sweeps a full turn of set bits
  access_row_t directed_tab [16] = '{
    '{'{CMD_READ,  16'h0000}, 1'b1, '{1'b0, 10'd0, 1'b0, 16'h0000, 1'b1, 1'b0}},
    '{'{CMD_WRITE, 16'hFFFF}, 1'b1, '{1'b0, 10'd1, 1'b0, 16'h0000, 1'b1, 1'b1}},
    '{'{CMD_READ,  16'h0000}, 1'b1, '{1'b1, 10'd0, 1'b0, 16'h0000, 1'b0, 1'b0}},
    '{'{CMD_WRITE, 16'hFFFF}, 1'b1, '{1'b1, 10'd1, 1'b0, 16'h0000, 1'b0, 1'b1}},
    '{'{CMD_WRITE, 16'h0000}, 1'b1, '{1'b1, 10'd0, 1'b0, 16'h0000, 1'b0, 1'b1}},
    '{'{CMD_READ,  16'h8000}, 1'b1, '{1'b0, 10'd2, 1'b0, 16'h0000, 1'b1, 1'b0}},
    '{'{CMD_READ,  16'h7FFF}, 1'b1, '{1'b0, 10'd3, 1'b0, 16'h0000, 1'b1, 1'b0}},
    '{'{CMD_WRITE, 16'h5555}, 1'b1, '{1'b0, 10'd4, 1'b0, 16'h0000, 1'b1, 1'b1}},
    '{'{CMD_WRITE, 16'hAAAA}, 1'b1, '{1'b0, 10'd5, 1'b0, 16'h0000, 1'b1, 1'b1}},
    '{'{CMD_READ,  16'h0001}, 1'b0, '0},
    '{'{CMD_READ,  16'h8000}, 1'b1, '{1'b1, 10'd2, 1'b0, 16'h0000, 1'b0, 1'b0}},
    '{'{CMD_READ,  16'h7FFF}, 1'b1, '{1'b1, 10'd3, 1'b0, 16'h0000, 1'b0, 1'b0}},
    '{'{CMD_READ,  16'h5555}, 1'b0, '0},
    '{'{CMD_WRITE, 16'hAAAA}, 1'b0, '0},
    '{'{CMD_READ,  16'hFFFE}, 1'b0, '0},
    '{'{CMD_WRITE, 16'h00FF}, 1'b0, '0}
  };

  buffer_pool_clock_replacement dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // works out the frame an access lands in and updates the frame table
  function automatic out_item_t lookup_frame(in_item_t acc);
    out_item_t res;
    int        f;
    int        slot;
    int        steps;
    res = '0;
    slot = -1;
    for (f = 0; f < NFRAMES; f++) begin
      if (slot < 0 && held[f] && page_of[f] == acc.page) slot = f;
    end
    if (slot >= 0) begin
      refb[slot] = 1'b1;
      res.hit = 1'b1;
      hit_count++;
    end else begin
      // second-chance sweep: set bits are cleared and passed over
      for (steps = 0; steps <= NFRAMES && slot < 0; steps++) begin
        f = hand;
        hand = (hand == NFRAMES - 1) ? 0 : hand + 1;
        if (!refb[f]) begin
          refb[f] = 1'b1;
          slot = f;
        end else begin
          refb[f] = 1'b0;
        end
      end
      if (steps == NFRAMES + 1) full_turns++;
      if (steps > longest_sweep) longest_sweep = steps;
      if (held[slot]) begin
        res.evicted_valid = 1'b1;
        res.evicted_page  = page_of[slot];
        evict_count++;
      end
      page_of[slot] = acc.page;
      held[slot]    = 1'b1;
      res.load_needed = 1'b1;
      miss_count++;
    end
    res.frame = slot[9:0];
    res.store_needed = (acc.command == CMD_WRITE);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  // present one access and hold it until the transfer happens
  task automatic send_access(in_item_t acc);
    while (!steady && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= acc;
    do @(posedge clk); while (in_stall);
  endtask

  // predict, queue the expectation and keep page history for later picks
  task automatic note_access(in_item_t acc, bit known, out_item_t typed);
    out_item_t res;
    res = lookup_frame(acc);
    pending_frames.push_back(known ? typed : res);
    recent_pages.push_back(acc.page);
    if (recent_pages.size() > HIST_DEPTH) void'(recent_pages.pop_front());
    if (res.evicted_valid) begin
      evicted_pages.push_back(res.evicted_page);
      if (evicted_pages.size() > HIST_DEPTH) void'(evicted_pages.pop_front());
    end
  endtask

  // receiver stall
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 18);
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = pending_frames.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch($sformatf("hit %b want %b", out_data.hit, want.hit));
        if (out_data.frame !== want.frame)
          report_mismatch($sformatf("frame %0d want %0d", out_data.frame, want.frame));
        if (out_data.evicted_valid !== want.evicted_valid)
          report_mismatch($sformatf("evicted_valid %b want %b",
                                    out_data.evicted_valid, want.evicted_valid));
        if (out_data.evicted_page !== want.evicted_page)
          report_mismatch($sformatf("evicted_page %h want %h",
                                    out_data.evicted_page, want.evicted_page));
        if (out_data.load_needed !== want.load_needed)
          report_mismatch($sformatf("load_needed %b want %b",
                                    out_data.load_needed, want.load_needed));
        if (out_data.store_needed !== want.store_needed)
          report_mismatch($sformatf("store_needed %b want %b",
                                    out_data.store_needed, want.store_needed));
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles with no transfer", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    in_item_t acc;
    int       r;
    for (int f = 0; f < NFRAMES; f++) begin
      page_of[f] = '0;
      held[f]    = 1'b0;
      refb[f]    = 1'b1;
    end
    hand = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_tab[i]) begin
      send_access(directed_tab[i].acc);
      note_access(directed_tab[i].acc, directed_tab[i].known, directed_tab[i].res);
    end

    // random accesses: mostly fresh pages so the pool fills and starts evicting
    for (int n = 0; n < RAND_ITEMS; n++) begin
      steady = (n >= 700 && n < 900);
      r = $urandom_range(99);
      acc.command = $urandom_range(1) ? CMD_WRITE : CMD_READ;
      if (r < 20 && recent_pages.size() > 0) begin
        acc.page = recent_pages[$urandom_range(recent_pages.size() - 1)];
      end else if (r < 23) begin
        case ($urandom_range(3))
          0: acc.page = 16'h0000;
          1: acc.page = 16'hFFFF;
          2: acc.page = 16'h0001 << $urandom_range(15);
          default: acc.page = ~(16'h0001 << $urandom_range(15));
        endcase
      end else if (r < 27 && evicted_pages.size() > 0) begin
        acc.page = evicted_pages[$urandom_range(evicted_pages.size() - 1)];
      end else begin
        acc.page = 16'($urandom_range(16'hFFFF));
      end
      send_access(acc);
      note_access(acc, 1'b0, '0);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain, then a short quiet spell to catch stray results
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d accesses: %0d hits, %0d misses, %0d evictions",
             hit_count + miss_count, hit_count, miss_count, evict_count);
    $display("sweeps: %0d full turns, longest %0d steps; %0d results checked",
             full_turns, longest_sweep, results_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bpcr_pkg.sv
design/bpcr_ram.sv
design/bpcr_datapath.sv
design/bpcr_ctrl.sv
design/buffer_pool_clock_replacement.sv
verif/tb.sv
